// ----- rtl/core/slpm_pkg.sv -----
// Shared types, constants and helpers for the LIKE pattern matcher.
package slpm_pkg;

    // Command codes, same encoding as the action field.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } op_t;

    localparam logic [7:0] CH_ANY_RUN = 8'h25;  // '%'
    localparam logic [7:0] CH_ANY_ONE = 8'h5F;  // '_'

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    // One queue slot as seen at either end: a command plus its valid flag.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } slot_t;

    // ASCII lower-casing when enabled.
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        if (en && (c inside {[8'h41:8'h5A]}))
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/slpm_ifs.sv -----
// Valid/ready channel interfaces for items and results.
interface slpm_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface slpm_result_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_too_long;

    modport source (output valid, output matched, output pattern_too_long, input ready);
    modport sink   (input valid, input matched, input pattern_too_long, output ready);
endinterface

// ----- rtl/core/slpm_front.sv -----
// Front end: takes item transactions, decodes the action and folds text bytes.
module slpm_front (
    slpm_item_if.sink    item,
    input  logic         case_fold,
    input  logic         queue_full,
    output slpm_pkg::slot_t push
);

    slpm_pkg::op_t op;

    assign op         = slpm_pkg::op_t'(item.action);
    assign item.ready = !queue_full;

    always_comb
    begin
        push.valid    = item.valid && !queue_full;
        push.cmd.op   = op;
        push.cmd.data = item.data_byte;
        case (op)
            slpm_pkg::OP_TEXT:
            begin
                // text side is folded once here; pattern side at compare time
                push.cmd.data = slpm_pkg::fold_byte(item.data_byte, case_fold);
            end
            default:
            begin
                push.cmd.data = item.data_byte;
            end
        endcase
    end

endmodule

// ----- rtl/core/slpm_queue.sv -----
// Small command FIFO between front and back ends.
module slpm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  slpm_pkg::slot_t push,
    input  logic            pop,
    output logic            full,
    output slpm_pkg::slot_t head
);

    localparam int PTR_W = (slpm_pkg::QUEUE_DEPTH > 1) ? $clog2(slpm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(slpm_pkg::QUEUE_DEPTH + 1);

    slpm_pkg::cmd_t   slot_mem [slpm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(slpm_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(slpm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(slpm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_mem[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

// ----- rtl/core/slpm_back.sv -----
// Back end: pattern cells, live position set with '%' closure, result register.
module slpm_back #(
    parameter int PATTERN_MAX = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            case_fold,
    input  slpm_pkg::slot_t head,
    output logic            pop,
    slpm_result_if.source   result
);

    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LIVE_W = PATTERN_MAX + 1;

    logic [7:0]        store_mem [PATTERN_MAX];
    logic [LEN_W-1:0]  len_reg;
    logic [LIVE_W-1:0] live_reg;    // set before closure
    logic              ovf_reg;
    logic              res_valid_reg;
    logic              matched_reg;
    logic              too_long_reg;

    logic [PATTERN_MAX-1:0] pct;    // cell holds '%' and is inside the pattern
    logic [PATTERN_MAX-1:0] adv;    // cell consumes the current text byte
    logic [LIVE_W-1:0]      run_mask;
    logic [LIVE_W-1:0]      seeds;
    logic [LIVE_W-1:0]      carry_sum;
    logic [LIVE_W-1:0]      live_eff;
    logic [LIVE_W-1:0]      live_step;
    logic                   full;
    logic                   out_free;
    logic                   is_end;
    logic                   is_append;

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pct[i] = (LEN_W'(i) < len_reg) && (store_mem[i] == slpm_pkg::CH_ANY_RUN);
            adv[i] = (LEN_W'(i) < len_reg) && (store_mem[i] != slpm_pkg::CH_ANY_RUN)
                     && ((store_mem[i] == slpm_pkg::CH_ANY_ONE)
                         || (slpm_pkg::fold_byte(store_mem[i], case_fold) == head.cmd.data));
        end
    end

    // Closure over '%' runs as a carry chain: a live bit on a '%' cell carries
    // through the run of '%' cells and lands on the cell after it.
    assign run_mask  = {1'b0, pct};
    assign seeds     = live_reg & run_mask;
    assign carry_sum = seeds + run_mask;
    assign live_eff  = live_reg | (carry_sum ^ seeds ^ run_mask);

    assign live_step = (live_eff & run_mask)
                     | {live_eff[PATTERN_MAX-1:0] & adv, 1'b0};

    assign full      = (len_reg == LEN_W'(PATTERN_MAX));
    assign out_free  = !res_valid_reg || result.ready;
    assign is_end    = (head.cmd.op == slpm_pkg::OP_END);
    assign is_append = (head.cmd.op == slpm_pkg::OP_APPEND);
    assign pop       = head.valid && (!is_end || out_free);

    assign result.valid            = res_valid_reg;
    assign result.matched          = matched_reg;
    assign result.pattern_too_long = too_long_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            live_reg      <= LIVE_W'(1);
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                case (head.cmd.op)
                    slpm_pkg::OP_CLEAR:
                    begin
                        len_reg  <= '0;
                        ovf_reg  <= 1'b0;
                        live_reg <= LIVE_W'(1);
                    end
                    slpm_pkg::OP_APPEND:
                    begin
                        if (full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            len_reg <= len_reg + LEN_W'(1);
                        end
                        live_reg <= LIVE_W'(1);
                    end
                    slpm_pkg::OP_TEXT:
                    begin
                        live_reg <= live_step;
                    end
                    slpm_pkg::OP_END:
                    begin
                        live_reg <= LIVE_W'(1);
                    end
                    default:
                    begin
                        live_reg <= live_reg;
                    end
                endcase
            end
            if (pop && is_end)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && is_end)
        begin
            matched_reg  <= live_eff[len_reg];
            too_long_reg <= ovf_reg;
        end
        if (pop && is_append && !full)
        begin
            store_mem[len_reg[IDX_W-1:0]] <= head.cmd.data;
        end
    end

endmodule

// ----- rtl/core/sql_like_pattern_matcher.sv -----
// Top level of the streaming SQL LIKE / ILIKE pattern matcher.
//
// Channels: "item" carries action/data_byte transactions (clear pattern,
// append pattern byte, text byte, end of string); "result" carries one
// matched/pattern_too_long transaction per end-of-string item. Both use
// valid/ready; a transaction moves on a rising edge with both high.
// cfg_write/cfg_data set case_fold (ILIKE); write it only while idle.
// Throughput: one item per cycle, except that an end-of-string item waits while
// a result is held. The live set update, the '%' closure (a PATTERN_MAX+1 bit
// carry chain) and the per-cell byte compares are all combinational in the back end.
// An accepted end-of-string item goes into the queue, then the back end executes
// it into the result register; a held result can stall it in the queue.
// Stall: while a result waits, the back end keeps executing pattern and text
// items; it holds only on an end-of-string item, and the two-entry queue
// then fills and drops item.ready.
// Reset: empty pattern, no overflow, case_fold 0, queue and result empty.
// Pattern bytes past PATTERN_MAX are dropped and flagged until a clear.
module sql_like_pattern_matcher #(
    parameter int PATTERN_MAX = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    slpm_item_if.sink     item,
    slpm_result_if.source result,
    input  logic          cfg_write,
    input  logic          cfg_data
);

    logic            case_fold_reg;
    slpm_pkg::slot_t push;
    slpm_pkg::slot_t head;
    logic            queue_full;
    logic            back_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_fold_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case_fold_reg <= cfg_data;
        end
    end

    // accept + decode
    slpm_front u_front (
        .item       (item),
        .case_fold  (case_fold_reg),
        .queue_full (queue_full),
        .push       (push)
    );

    // decouples acceptance from execution
    slpm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (back_pop),
        .full  (queue_full),
        .head  (head)
    );

    // pattern cells, live set and result register
    slpm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .case_fold (case_fold_reg),
        .head      (head),
        .pop       (back_pop),
        .result    (result)
    );

`ifndef SYNTH
    // back end only consumes commands that are present
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        back_pop |-> head.valid)
        else $error("back end popped an empty queue");

    // a new result only follows execution of an end-of-string command
    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(back_pop && head.cmd.op == slpm_pkg::OP_END))
        else $error("result raised without an end-of-string command");

    // no push into a full queue
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> !push.valid)
        else $error("push into full queue");
`endif

endmodule
